// ===== hdl/acsc_pkg.sv =====
// Shared types, codes and BCD digit-step functions for the alarm clock set controller.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
package acsc_pkg;

   // ui mode codes
   localparam logic [2:0] MODE_UNSET  = 3'd0;
   localparam logic [2:0] MODE_NORMAL = 3'd1;
   localparam logic [2:0] MODE_SET_H  = 3'd2;
   localparam logic [2:0] MODE_SET_M  = 3'd3;
   localparam logic [2:0] MODE_ALM_H  = 3'd4;
   localparam logic [2:0] MODE_ALM_M  = 3'd5;

   // key bit positions
   localparam int KEY_F1     = 0;
   localparam int KEY_F2     = 1;
   localparam int KEY_DOWN   = 2;
   localparam int KEY_UP     = 3;
   localparam int KEY_ACCEPT = 4;
   localparam int KEY_CANCEL = 5;

   // flash commands
   localparam logic [1:0] FLASH_NONE    = 2'd0;
   localparam logic [1:0] FLASH_HOURS   = 2'd1;
   localparam logic [1:0] FLASH_MINUTES = 2'd2;
   localparam logic [1:0] FLASH_OFF     = 2'd3;

   // item kinds
   localparam logic ITEM_TICK   = 1'b0;
   localparam logic ITEM_SAMPLE = 1'b1;

   // configuration register indexes and reset values
   localparam logic [1:0] CSR_LOCKOUT_TICKS    = 2'd0;
   localparam logic [1:0] CSR_TICKS_PER_SECOND = 2'd1;
   localparam logic [1:0] CSR_BLINK_TICKS      = 2'd2;
   localparam logic [9:0]  LOCKOUT_TICKS_RESET    = 10'd250;
   localparam logic [11:0] TICKS_PER_SECOND_RESET = 12'd1000;
   localparam logic [11:0] BLINK_TICKS_RESET      = 12'd500;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   typedef struct packed {
      logic        mode;
      logic [5:0]  keys;
      logic        buzzer_active;
      logic        time_valid;
      logic [15:0] current_time;
      logic [15:0] alarm_time;
   } req_type;

   typedef struct packed {
      logic        second_tick;
      logic        dots_toggle;
      logic        silence_buzzer;
      logic        postpone_alarm;
      logic        alarm_write;
      logic        alarm_value;
      logic        commit_time;
      logic        commit_alarm;
      logic [15:0] edit_digits;
      logic [1:0]  flash_cmd;
      logic        display_write;
      logic [15:0] display_digits;
   } rsp_type;

   typedef struct packed {
      logic [9:0]  lockout_ticks;
      logic [11:0] ticks_per_second;
      logic [11:0] blink_ticks;
   } cfg_type;

   // hours step up, 00..23; carries wrap inside their nibble
   function automatic logic [15:0] hour_up(input logic [15:0] v);
      logic [3:0] a;
      logic [4:0] b;
      a = v[15:12];
      b = {1'b0, v[11:8]} + 5'd1;
      if (a == 4'd2 && b > 5'd3) begin
         a = 4'd0;
         b = 5'd0;
      end else if (b > 5'd9) begin
         b = 5'd0;
         a = a + 4'd1;
      end
      return {a, b[3:0], v[7:0]};
   endfunction

   function automatic logic [15:0] hour_down(input logic [15:0] v);
      logic [3:0] a;
      logic [3:0] b;
      a = v[15:12];
      b = v[11:8];
      if (a == 4'd0 && b == 4'd0) begin
         a = 4'd2;
         b = 4'd3;
      end else if (b == 4'd0) begin
         b = 4'd9;
         a = a - 4'd1;
      end else begin
         b = b - 4'd1;
      end
      return {a, b, v[7:0]};
   endfunction

   // minutes step up, 00..59; the tens compare applies with or without carry
   function automatic logic [15:0] min_up(input logic [15:0] v);
      logic [4:0] c;
      logic [4:0] d;
      c = {1'b0, v[7:4]};
      d = {1'b0, v[3:0]} + 5'd1;
      if (d > 5'd9) begin
         d = 5'd0;
         c = c + 5'd1;
      end
      if (c > 5'd5) begin
         c = 5'd0;
      end
      return {v[15:8], c[3:0], d[3:0]};
   endfunction

   function automatic logic [15:0] min_down(input logic [15:0] v);
      logic [3:0] c;
      logic [3:0] d;
      c = v[7:4];
      d = v[3:0];
      if (c == 4'd0 && d == 4'd0) begin
         c = 4'd5;
         d = 4'd9;
      end else if (d == 4'd0) begin
         d = 4'd9;
         c = c - 4'd1;
      end else begin
         d = d - 4'd1;
      end
      return {v[15:8], c, d};
   endfunction

endpackage

// ===== hdl/acsc_ifs.sv =====
// Channel interfaces of the alarm clock set controller: item, result and register write.
// Depends on acsc_pkg for field widths.
interface acsc_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [5:0]  keys;
   logic        buzzer_active;
   logic        time_valid;
   logic [15:0] current_time;
   logic [15:0] alarm_time;
   modport source (output valid, mode, keys, buzzer_active, time_valid, current_time,
                   alarm_time, input ready);
   modport sink   (input valid, mode, keys, buzzer_active, time_valid, current_time,
                   alarm_time, output ready);
endinterface

interface acsc_rsp_if;
   logic        valid;
   logic        ready;
   logic        second_tick;
   logic        dots_toggle;
   logic        silence_buzzer;
   logic        postpone_alarm;
   logic        alarm_write;
   logic        alarm_value;
   logic        commit_time;
   logic        commit_alarm;
   logic [15:0] edit_digits;
   logic [1:0]  flash_cmd;
   logic        display_write;
   logic [15:0] display_digits;
   modport source (output valid, second_tick, dots_toggle, silence_buzzer, postpone_alarm,
                   alarm_write, alarm_value, commit_time, commit_alarm, edit_digits,
                   flash_cmd, display_write, display_digits, input ready);
   modport sink   (input valid, second_tick, dots_toggle, silence_buzzer, postpone_alarm,
                   alarm_write, alarm_value, commit_time, commit_alarm, edit_digits,
                   flash_cmd, display_write, display_digits, output ready);
endinterface

interface acsc_csr_if;
   logic                              valid;
   logic                              ready;
   logic [acsc_pkg::CSR_INDEX_W-1:0]  index;
   logic [acsc_pkg::CSR_DATA_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/alarm_clock_set_controller_top.sv =====
// Top level of the alarm clock set controller: input register, step core, result register.
// Depends on acsc_pkg, acsc_ifs (channel interfaces), acsc_csr and acsc_core.
//
//   channel    port       direction  moves per word
//   ---------  ---------  ---------  ----------------------------------------------
//   item       req_chan   in         tick or key sample with time and alarm digits
//   result     rsp_chan   out        pulses, commands, edit and display digits
//   register   csr_chan   in         register index and write data
//
// Every item is held in the input register, then goes through the step logic into the
// result register. One item is accepted every cycle while the result is not stalled.
// Reset is synchronous and restores the mode machine, counters and register defaults.
// A stalled result holds in its register while the input register still fills; the step
// into the result register waits until that register is free or being taken.
module alarm_clock_set_controller_top (
   input  logic        clock,
   input  logic        reset,
   acsc_req_if.sink    req_chan,
   acsc_rsp_if.source  rsp_chan,
   acsc_csr_if.sink    csr_chan
);

   acsc_pkg::cfg_type cfg;
   acsc_pkg::req_type req_word;
   acsc_pkg::req_type item_ff;
   acsc_pkg::rsp_type step_result;
   acsc_pkg::rsp_type rsp_ff;
   logic              item_valid_ff;
   logic              rsp_valid_ff;
   logic              advance;

   acsc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // step the item held in the input register when the result register can take it
   assign advance        = item_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !item_valid_ff || advance;

   always_comb begin
      req_word.mode          = req_chan.mode;
      req_word.keys          = req_chan.keys;
      req_word.buzzer_active = req_chan.buzzer_active;
      req_word.time_valid    = req_chan.time_valid;
      req_word.current_time  = req_chan.current_time;
      req_word.alarm_time    = req_chan.alarm_time;
   end

   acsc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (step_result)
   );

   // input register: load on accept, drop once stepped
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         item_valid_ff <= 1'b1;
      end else if (advance) begin
         item_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         item_ff <= req_word;
      end
   end

   // result register: load on step, hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.second_tick    = rsp_ff.second_tick;
   assign rsp_chan.dots_toggle    = rsp_ff.dots_toggle;
   assign rsp_chan.silence_buzzer = rsp_ff.silence_buzzer;
   assign rsp_chan.postpone_alarm = rsp_ff.postpone_alarm;
   assign rsp_chan.alarm_write    = rsp_ff.alarm_write;
   assign rsp_chan.alarm_value    = rsp_ff.alarm_value;
   assign rsp_chan.commit_time    = rsp_ff.commit_time;
   assign rsp_chan.commit_alarm   = rsp_ff.commit_alarm;
   assign rsp_chan.edit_digits    = rsp_ff.edit_digits;
   assign rsp_chan.flash_cmd      = rsp_ff.flash_cmd;
   assign rsp_chan.display_write  = rsp_ff.display_write;
   assign rsp_chan.display_digits = rsp_ff.display_digits;

endmodule

// ===== hdl/acsc_csr.sv =====
// Configuration registers of the alarm clock set controller.
// Depends on acsc_pkg and acsc_csr_if.
module acsc_csr (
   input  logic                 clock,
   input  logic                 reset,
   acsc_csr_if.sink             csr_chan,
   output acsc_pkg::cfg_type    cfg
);

   acsc_pkg::cfg_type cfg_ff;
   acsc_pkg::cfg_type cfg_in;

   assign csr_chan.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_chan.valid) begin
         case (csr_chan.index)
            acsc_pkg::CSR_LOCKOUT_TICKS:    cfg_in.lockout_ticks    = csr_chan.data[9:0];
            acsc_pkg::CSR_TICKS_PER_SECOND: cfg_in.ticks_per_second = csr_chan.data;
            acsc_pkg::CSR_BLINK_TICKS:      cfg_in.blink_ticks      = csr_chan.data;
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lockout_ticks    <= acsc_pkg::LOCKOUT_TICKS_RESET;
         cfg_ff.ticks_per_second <= acsc_pkg::TICKS_PER_SECOND_RESET;
         cfg_ff.blink_ticks      <= acsc_pkg::BLINK_TICKS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hdl/acsc_core.sv =====
// State registers and one-item step logic: timers, key lockout, mode machine, display.
// Depends on acsc_pkg.
module acsc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  acsc_pkg::req_type    item,
   input  acsc_pkg::cfg_type    cfg,
   output acsc_pkg::rsp_type    result
);

   logic [2:0]  mode_ff,    mode_in;
   logic [15:0] edit_ff,    edit_in;
   logic [9:0]  lock_ff,    lock_in;
   logic [11:0] millis_ff,  millis_in;
   logic [11:0] blink_ff,   blink_in;
   logic [15:0] shown_ff,   shown_in;
   logic        known_ff,   known_in;

   logic [5:0]  keys;
   logic [15:0] shown;

   always_comb begin
      mode_in   = mode_ff;
      edit_in   = edit_ff;
      lock_in   = lock_ff;
      millis_in = millis_ff;
      blink_in  = blink_ff;
      shown_in  = shown_ff;
      known_in  = known_ff;
      result    = '0;
      keys      = '0;
      shown     = '0;

      if (item.mode == acsc_pkg::ITEM_TICK) begin
         if (lock_ff != 10'd0) begin
            lock_in = lock_ff - 10'd1;
         end
         millis_in = millis_ff + 12'd1;
         if (millis_in >= cfg.ticks_per_second) begin
            millis_in = 12'd0;
            result.second_tick = 1'b1;
         end
         if (mode_ff == acsc_pkg::MODE_NORMAL) begin
            blink_in = blink_ff + 12'd1;
            if (blink_in >= cfg.blink_ticks) begin
               blink_in = 12'd0;
               result.dots_toggle = 1'b1;
            end
         end
      end else begin
         // drop keys during lockout, restart it on any accepted press
         if (lock_ff == 10'd0) begin
            keys = item.keys;
            if (item.keys != 6'd0) begin
               lock_in = cfg.lockout_ticks;
            end
         end

         case (mode_ff)
            acsc_pkg::MODE_UNSET: begin
               if (keys[acsc_pkg::KEY_F1]) begin
                  mode_in = acsc_pkg::MODE_SET_H;
                  result.flash_cmd = acsc_pkg::FLASH_HOURS;
                  edit_in = 16'd0;
               end
            end
            acsc_pkg::MODE_NORMAL: begin
               if (item.buzzer_active) begin
                  if (keys[acsc_pkg::KEY_ACCEPT]) begin
                     result.silence_buzzer = 1'b1;
                     result.postpone_alarm = 1'b1;
                  end
                  if (keys[acsc_pkg::KEY_CANCEL]) begin
                     result.silence_buzzer = 1'b1;
                  end
               end else begin
                  if (keys[acsc_pkg::KEY_ACCEPT]) begin
                     result.alarm_write = 1'b1;
                     result.alarm_value = 1'b1;
                  end
                  if (keys[acsc_pkg::KEY_CANCEL]) begin
                     result.alarm_write = 1'b1;
                     result.alarm_value = 1'b0;
                  end
                  if (keys[acsc_pkg::KEY_F1]) begin
                     mode_in = acsc_pkg::MODE_SET_H;
                     result.flash_cmd = acsc_pkg::FLASH_HOURS;
                     edit_in = item.current_time;
                  end
                  if (keys[acsc_pkg::KEY_F2]) begin
                     mode_in = acsc_pkg::MODE_ALM_H;
                     result.flash_cmd = acsc_pkg::FLASH_HOURS;
                     edit_in = item.alarm_time;
                  end
               end
            end
            acsc_pkg::MODE_SET_H, acsc_pkg::MODE_ALM_H: begin
               if (keys[acsc_pkg::KEY_UP]) begin
                  edit_in = acsc_pkg::hour_up(edit_in);
               end
               if (keys[acsc_pkg::KEY_DOWN]) begin
                  edit_in = acsc_pkg::hour_down(edit_in);
               end
               if (keys[acsc_pkg::KEY_ACCEPT]) begin
                  mode_in = (mode_ff == acsc_pkg::MODE_SET_H) ? acsc_pkg::MODE_SET_M
                                                               : acsc_pkg::MODE_ALM_M;
                  result.flash_cmd = acsc_pkg::FLASH_MINUTES;
               end
               if (keys[acsc_pkg::KEY_CANCEL]) begin
                  mode_in = acsc_pkg::MODE_NORMAL;
                  result.flash_cmd = acsc_pkg::FLASH_OFF;
               end
            end
            acsc_pkg::MODE_SET_M, acsc_pkg::MODE_ALM_M: begin
               if (keys[acsc_pkg::KEY_UP]) begin
                  edit_in = acsc_pkg::min_up(edit_in);
               end
               if (keys[acsc_pkg::KEY_DOWN]) begin
                  edit_in = acsc_pkg::min_down(edit_in);
               end
               if (keys[acsc_pkg::KEY_ACCEPT]) begin
                  if (mode_ff == acsc_pkg::MODE_SET_M) begin
                     result.commit_time = 1'b1;
                  end else begin
                     result.commit_alarm = 1'b1;
                  end
                  mode_in = acsc_pkg::MODE_NORMAL;
                  result.flash_cmd = acsc_pkg::FLASH_OFF;
               end
               if (keys[acsc_pkg::KEY_CANCEL]) begin
                  mode_in = acsc_pkg::MODE_NORMAL;
                  result.flash_cmd = acsc_pkg::FLASH_OFF;
               end
            end
            default: begin
               mode_in = mode_ff;
            end
         endcase

         if (mode_in == acsc_pkg::MODE_NORMAL) begin
            shown = item.time_valid ? item.current_time : 16'd0;
         end else begin
            shown = edit_in;
         end
         if (!known_ff || shown != shown_ff) begin
            shown_in = shown;
            known_in = 1'b1;
            result.display_write  = 1'b1;
            result.display_digits = shown;
         end
      end
      result.edit_digits = edit_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= acsc_pkg::MODE_UNSET;
         edit_ff   <= 16'd0;
         lock_ff   <= 10'd0;
         millis_ff <= 12'd0;
         blink_ff  <= 12'd0;
         shown_ff  <= 16'd0;
         known_ff  <= 1'b0;
      end else if (step_en) begin
         mode_ff   <= mode_in;
         edit_ff   <= edit_in;
         lock_ff   <= lock_in;
         millis_ff <= millis_in;
         blink_ff  <= blink_in;
         shown_ff  <= shown_in;
         known_ff  <= known_in;
      end
   end

endmodule

// ===== tb/alarm_clock_set_controller_top_test.sv =====
// Self-checking testbench for the alarm clock set controller: directed and random
// tick and key-sample words against a cycle-free behavioral predictor of the mode machine.
// Depends on acsc_pkg, the channel interfaces in acsc_ifs and the top level RTL.
module alarm_clock_set_controller_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import acsc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_AT     = 150;   // accepted words before the long receiver hold
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_WAIT    = 18;
   localparam int DRAIN_WAIT  = 20;

   // the register index space has one slot with no register behind it
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   localparam logic [5:0] PRESS_NONE   = 6'b0;
   localparam logic [5:0] PRESS_F1     = 6'b1 << KEY_F1;
   localparam logic [5:0] PRESS_F2     = 6'b1 << KEY_F2;
   localparam logic [5:0] PRESS_DOWN   = 6'b1 << KEY_DOWN;
   localparam logic [5:0] PRESS_UP     = 6'b1 << KEY_UP;
   localparam logic [5:0] PRESS_ACCEPT = 6'b1 << KEY_ACCEPT;
   localparam logic [5:0] PRESS_CANCEL = 6'b1 << KEY_CANCEL;

   logic clock = 1'b0;
   logic reset;

   acsc_req_if req_chan ();
   acsc_rsp_if rsp_chan ();
   acsc_csr_if csr_chan ();

   alarm_clock_set_controller_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------------------
   // Predicted controller state and register copies
   // ---------------------------------------------------------------------------------
   logic [2:0]  ui_state;
   logic [15:0] edit_word;
   logic [9:0]  lock_left;
   logic [11:0] milli_count;
   logic [11:0] dot_count;
   logic [15:0] shown_word;
   logic        shown_valid;

   logic [9:0]  lockout_reg;
   logic [11:0] tick_period_reg;
   logic [11:0] blink_period_reg;

   req_type pending_items[$];      // words waiting for the driver
   rsp_type expected_outputs[$];   // predicted result words, oldest first

   req_type sent_item;
   int      send_gap;
   int      recv_gap;
   int      hold_left;
   bit      hold_done;
   int      items_accepted;
   int      results_seen;
   int      queued_total;
   int      cycle_count = 0;
   int      send_idle_pct;
   int      recv_idle_pct;
   int      mismatches;

   int      tick_total;
   int      sample_total;
   int      reg_writes;
   int      display_writes;
   int      time_commits;
   int      alarm_commits;

   // Step the hour digits one up or down; 23 wraps to 00 and a carry stays in its nibble.
   function automatic logic [15:0] step_hours(input logic [15:0] v, input bit up);
      logic [3:0] tens;
      logic [4:0] ones;
      tens = v[15:12];
      ones = {1'b0, v[11:8]};
      if (up) begin
         ones = ones + 5'd1;
         if (tens == 4'd2 && ones > 5'd3) begin
            tens = 4'd0;
            ones = 5'd0;
         end else if (ones > 5'd9) begin
            ones = 5'd0;
            tens = tens + 4'd1;
         end
      end else begin
         if (tens == 4'd0 && ones == 5'd0) begin
            tens = 4'd2;
            ones = 5'd3;
         end else if (ones == 5'd0) begin
            ones = 5'd9;
            tens = tens - 4'd1;
         end else begin
            ones = ones - 5'd1;
         end
      end
      return {tens, ones[3:0], v[7:0]};
   endfunction

   // Step the minute digits; the tens limit applies whether or not a carry came in.
   function automatic logic [15:0] step_minutes(input logic [15:0] v, input bit up);
      logic [4:0] tens;
      logic [4:0] ones;
      tens = {1'b0, v[7:4]};
      ones = {1'b0, v[3:0]};
      if (up) begin
         ones = ones + 5'd1;
         if (ones > 5'd9) begin
            ones = 5'd0;
            tens = tens + 5'd1;
         end
         if (tens > 5'd5) begin
            tens = 5'd0;
         end
      end else begin
         if (tens == 5'd0 && ones == 5'd0) begin
            tens = 5'd5;
            ones = 5'd9;
         end else if (ones == 5'd0) begin
            ones = 5'd9;
            tens = tens - 5'd1;
         end else begin
            ones = ones - 5'd1;
         end
      end
      return {v[15:8], tens[3:0], ones[3:0]};
   endfunction

   // Advance the predicted controller by one accepted word and return its result word.
   function automatic rsp_type controller_outputs(input req_type w);
      rsp_type     r;
      logic [5:0]  k;
      logic [15:0] shown;
      r = '0;
      if (w.mode == ITEM_TICK) begin
         tick_total++;
         if (lock_left != 10'd0) begin
            lock_left = lock_left - 10'd1;
         end
         milli_count = milli_count + 12'd1;
         if (milli_count >= tick_period_reg) begin
            milli_count   = 12'd0;
            r.second_tick = 1'b1;
         end
         if (ui_state == MODE_NORMAL) begin
            dot_count = dot_count + 12'd1;
            if (dot_count >= blink_period_reg) begin
               dot_count     = 12'd0;
               r.dots_toggle = 1'b1;
            end
         end
      end else begin
         sample_total++;
         k = w.keys;
         if (lock_left != 10'd0) begin
            k = '0;
         end else if (k != '0) begin
            lock_left = lockout_reg;
         end
         case (ui_state)
            MODE_UNSET: begin
               if (k[KEY_F1]) begin
                  ui_state    = MODE_SET_H;
                  r.flash_cmd = FLASH_HOURS;
                  edit_word   = 16'h0000;
               end
            end
            MODE_NORMAL: begin
               if (w.buzzer_active) begin
                  if (k[KEY_ACCEPT]) begin
                     r.silence_buzzer = 1'b1;
                     r.postpone_alarm = 1'b1;
                  end
                  if (k[KEY_CANCEL]) r.silence_buzzer = 1'b1;
               end else begin
                  if (k[KEY_ACCEPT]) begin
                     r.alarm_write = 1'b1;
                     r.alarm_value = 1'b1;
                  end
                  if (k[KEY_CANCEL]) begin
                     r.alarm_write = 1'b1;
                     r.alarm_value = 1'b0;
                  end
                  if (k[KEY_F1]) begin
                     ui_state    = MODE_SET_H;
                     r.flash_cmd = FLASH_HOURS;
                     edit_word   = w.current_time;
                  end
                  if (k[KEY_F2]) begin
                     ui_state    = MODE_ALM_H;
                     r.flash_cmd = FLASH_HOURS;
                     edit_word   = w.alarm_time;
                  end
               end
            end
            MODE_SET_H, MODE_ALM_H: begin
               if (k[KEY_UP])   edit_word = step_hours(edit_word, 1'b1);
               if (k[KEY_DOWN]) edit_word = step_hours(edit_word, 1'b0);
               if (k[KEY_ACCEPT]) begin
                  ui_state    = (ui_state == MODE_SET_H) ? MODE_SET_M : MODE_ALM_M;
                  r.flash_cmd = FLASH_MINUTES;
               end
               if (k[KEY_CANCEL]) begin
                  ui_state    = MODE_NORMAL;
                  r.flash_cmd = FLASH_OFF;
               end
            end
            MODE_SET_M, MODE_ALM_M: begin
               if (k[KEY_UP])   edit_word = step_minutes(edit_word, 1'b1);
               if (k[KEY_DOWN]) edit_word = step_minutes(edit_word, 1'b0);
               if (k[KEY_ACCEPT]) begin
                  if (ui_state == MODE_SET_M) r.commit_time = 1'b1;
                  else r.commit_alarm = 1'b1;
                  ui_state    = MODE_NORMAL;
                  r.flash_cmd = FLASH_OFF;
               end
               if (k[KEY_CANCEL]) begin
                  ui_state    = MODE_NORMAL;
                  r.flash_cmd = FLASH_OFF;
               end
            end
            default: ;
         endcase
         if (ui_state == MODE_NORMAL) shown = w.time_valid ? w.current_time : 16'h0000;
         else shown = edit_word;
         if (!shown_valid || shown != shown_word) begin
            shown_word       = shown;
            shown_valid      = 1'b1;
            r.display_write  = 1'b1;
            r.display_digits = shown;
         end
         if (r.display_write) display_writes++;
         if (r.commit_time)   time_commits++;
         if (r.commit_alarm)  alarm_commits++;
      end
      r.edit_digits = edit_word;
      return r;
   endfunction

   // Draw the idle cycles before the next word; pct sets how often a side idles at all.
   function automatic int draw_wait(input int pct);
      if ($urandom_range(0, 99) < pct) return $urandom_range(0, MAX_WAIT);
      return 0;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatches++;
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Driver: present queued words, hold them while stalled, idle between words
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : drive_items
      req_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap       <= 0;
         items_accepted <= 0;
      end else begin
         // a word moved: predict its result right away, in acceptance order
         if (req_chan.valid && req_chan.ready) begin
            expected_outputs.push_back(controller_outputs(sent_item));
            items_accepted <= items_accepted + 1;
         end
         // advance only when the channel is empty or the current word just moved
         if (!req_chan.valid || req_chan.ready) begin
            if (send_gap != 0) begin
               send_gap       <= send_gap - 1;
               req_chan.valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
               nxt                    = pending_items.pop_front();
               sent_item              <= nxt;
               req_chan.mode          <= nxt.mode;
               req_chan.keys          <= nxt.keys;
               req_chan.buzzer_active <= nxt.buzzer_active;
               req_chan.time_valid    <= nxt.time_valid;
               req_chan.current_time  <= nxt.current_time;
               req_chan.alarm_time    <= nxt.alarm_time;
               req_chan.valid         <= 1'b1;
               send_gap               <= draw_wait(send_idle_pct);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Long receiver hold: drop ready for a stretch once, while the sender keeps offering,
   // so both pipeline registers fill and the block stalls its input
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : long_hold
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && items_accepted == HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------------------------
   // Monitor: take result words, compare each field with the oldest prediction
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      rsp_type want;
      int      stall;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_gap       <= 0;
         results_seen   <= 0;
      end else begin
         stall = recv_gap;
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen <= results_seen + 1;
            if (expected_outputs.size() == 0) begin
               $error("result word arrived with no prediction waiting");
               mismatches++;
            end else begin
               want = expected_outputs.pop_front();
               check_field("second_tick",    want.second_tick,    rsp_chan.second_tick);
               check_field("dots_toggle",    want.dots_toggle,    rsp_chan.dots_toggle);
               check_field("silence_buzzer", want.silence_buzzer, rsp_chan.silence_buzzer);
               check_field("postpone_alarm", want.postpone_alarm, rsp_chan.postpone_alarm);
               check_field("alarm_write",    want.alarm_write,    rsp_chan.alarm_write);
               check_field("alarm_value",    want.alarm_value,    rsp_chan.alarm_value);
               check_field("commit_time",    want.commit_time,    rsp_chan.commit_time);
               check_field("commit_alarm",   want.commit_alarm,   rsp_chan.commit_alarm);
               check_field("edit_digits",    want.edit_digits,    rsp_chan.edit_digits);
               check_field("flash_cmd",      want.flash_cmd,      rsp_chan.flash_cmd);
               check_field("display_write",  want.display_write,  rsp_chan.display_write);
               check_field("display_digits", want.display_digits, rsp_chan.display_digits);
            end
            stall = draw_wait(recv_idle_pct);
         end
         // hold off during the long stall, then the drawn per-word stall, else take
         if (hold_left != 0) begin
            rsp_chan.ready <= 1'b0;
         end else if (stall != 0) begin
            stall          = stall - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
         recv_gap <= stall;
      end
   end

   // Watchdog: end a hung run.
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------

   // Write one register and mirror it into the predictor copy once it is taken.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      case (idx)
         CSR_LOCKOUT_TICKS:    lockout_reg      = value[9:0];
         CSR_TICKS_PER_SECOND: tick_period_reg  = value;
         CSR_BLINK_TICKS:      blink_period_reg = value;
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic program_regs(input logic [11:0] lockout, input logic [11:0] tick_period,
                               input logic [11:0] blink_period);
      write_reg(CSR_LOCKOUT_TICKS, lockout);
      write_reg(CSR_TICKS_PER_SECOND, tick_period);
      write_reg(CSR_BLINK_TICKS, blink_period);
   endtask

   // Set idling for the coming words; step off the rising edge before queueing.
   task automatic set_idling(input int send_pct, input int recv_pct);
      @(negedge clock);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // Wait until every queued word has produced its result word.
   task automatic drain();
      while (results_seen != queued_total) @(posedge clock);
   endtask

   function automatic logic [15:0] random_time();
      int hh;
      int mm;
      if ($urandom_range(0, 9) == 0) return 16'($urandom);
      hh = $urandom_range(0, 23);
      mm = $urandom_range(0, 59);
      return {4'(hh / 10), 4'(hh % 10), 4'(mm / 10), 4'(mm % 10)};
   endfunction

   task automatic queue_word(input logic mode, input logic [5:0] keys, input logic buzz,
                             input logic tvalid, input logic [15:0] cur,
                             input logic [15:0] alm);
      req_type w;
      w.mode          = mode;
      w.keys          = keys;
      w.buzzer_active = buzz;
      w.time_valid    = tvalid;
      w.current_time  = cur;
      w.alarm_time    = alm;
      pending_items.push_back(w);
      queued_total++;
   endtask

   // Ticks carry random content in the fields the block ignores.
   task automatic queue_ticks(input int n);
      repeat (n) queue_word(ITEM_TICK, 6'($urandom), 1'($urandom), 1'($urandom),
                            16'($urandom), 16'($urandom));
   endtask

   task automatic queue_sample(input logic [5:0] keys, input logic buzz,
                               input logic tvalid, input logic [15:0] cur,
                               input logic [15:0] alm);
      queue_word(ITEM_SAMPLE, keys, buzz, tvalid, cur, alm);
   endtask

   // A key press followed by enough ticks to clear the lockout; now and then too few,
   // so that the next press gets dropped.
   task automatic queue_press(input logic [5:0] keys, input logic buzz);
      int settle;
      settle = lockout_reg;
      if ($urandom_range(0, 9) == 0) settle = $urandom_range(0, settle);
      queue_sample(keys, buzz, $urandom_range(0, 9) != 0, random_time(), random_time());
      queue_ticks(settle);
   endtask

   function automatic logic [5:0] step_keys();
      case ($urandom_range(0, 6))
         0, 1:    return PRESS_UP;
         2, 3:    return PRESS_DOWN;
         4:       return PRESS_UP | PRESS_DOWN;
         5:       return PRESS_NONE;
         default: return 6'($urandom);
      endcase
   endfunction

   // One edit session: optional alarm handling, enter a set mode, step hours, move on,
   // step minutes, then commit or abandon.
   task automatic queue_session();
      if ($urandom_range(0, 2) == 0)
         queue_press($urandom_range(0, 1) ? PRESS_ACCEPT : PRESS_CANCEL, 1'($urandom));
      case ($urandom_range(0, 4))
         0, 1:    queue_press(PRESS_F1, 1'b0);
         2, 3:    queue_press(PRESS_F2, 1'b0);
         default: queue_press(PRESS_F1 | PRESS_F2, 1'b0);
      endcase
      repeat ($urandom_range(0, 5)) queue_press(step_keys(), 1'($urandom));
      queue_press(($urandom_range(0, 9) == 0) ? PRESS_CANCEL : PRESS_ACCEPT, 1'($urandom));
      repeat ($urandom_range(0, 5)) queue_press(step_keys(), 1'($urandom));
      case ($urandom_range(0, 3))
         0, 1:    queue_press(PRESS_ACCEPT, 1'($urandom));
         2:       queue_press(PRESS_CANCEL, 1'($urandom));
         default: queue_press(PRESS_ACCEPT | PRESS_CANCEL, 1'($urandom));
      endcase
   endtask

   task automatic queue_noise();
      if ($urandom_range(0, 9) < 4) queue_ticks(1);
      else queue_sample(6'($urandom), 1'($urandom), 1'($urandom), 16'($urandom),
                        16'($urandom));
   endtask

   // Mostly well-formed edit sessions while the lockout is short, else noise.
   task automatic fill_random(input int n);
      int start;
      start = queued_total;
      while (queued_total - start < n) begin
         if (lockout_reg <= 10'd16 && $urandom_range(0, 99) < 65) queue_session();
         else queue_noise();
      end
   endtask

   // ---------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------
   initial begin
      reset                  = 1'b1;
      req_chan.valid         = 1'b0;
      req_chan.mode          = ITEM_TICK;
      req_chan.keys          = '0;
      req_chan.buzzer_active = 1'b0;
      req_chan.time_valid    = 1'b0;
      req_chan.current_time  = '0;
      req_chan.alarm_time    = '0;
      rsp_chan.ready         = 1'b0;
      csr_chan.valid         = 1'b0;
      csr_chan.index         = '0;
      csr_chan.data          = '0;
      ui_state               = MODE_UNSET;
      edit_word              = '0;
      lock_left              = '0;
      milli_count            = '0;
      dot_count              = '0;
      shown_word             = '0;
      shown_valid            = 1'b0;
      lockout_reg            = LOCKOUT_TICKS_RESET;
      tick_period_reg        = TICKS_PER_SECOND_RESET;
      blink_period_reg       = BLINK_TICKS_RESET;
      send_idle_pct          = 30;
      recv_idle_pct          = 30;
      queued_total           = 0;
      mismatches             = 0;
      tick_total             = 0;
      sample_total           = 0;
      reg_writes             = 0;
      display_writes         = 0;
      time_commits           = 0;
      alarm_commits          = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: no lockout and short periods so each press and tick shows its effect.
      program_regs(12'd0, 12'd3, 12'd2);
      set_idling(30, 30);
      queue_ticks(1);
      queue_sample(PRESS_NONE, 1'b0, 1'b1, 16'h1234, 16'h0630);  // first display write
      queue_sample(PRESS_F1, 1'b0, 1'b1, 16'h1234, 16'h0630);    // unset to set hours
      queue_sample(PRESS_UP, 1'b0, 1'b1, 16'h1234, 16'h0630);
      queue_sample(PRESS_UP | PRESS_DOWN, 1'b0, 1'b1, 16'h1234, 16'h0630);
      queue_sample(PRESS_DOWN, 1'b0, 1'b1, 16'h1234, 16'h0630);
      queue_sample(PRESS_DOWN, 1'b0, 1'b1, 16'h1234, 16'h0630);  // 00 wraps to 23
      queue_sample(PRESS_UP, 1'b0, 1'b1, 16'h1234, 16'h0630);    // 23 wraps to 00
      queue_sample(PRESS_ACCEPT, 1'b0, 1'b1, 16'h1234, 16'h0630);
      queue_sample(PRESS_DOWN, 1'b0, 1'b1, 16'h1234, 16'h0630);  // 00 wraps to 59
      queue_sample(PRESS_UP, 1'b0, 1'b1, 16'h1234, 16'h0630);
      queue_sample(PRESS_ACCEPT, 1'b0, 1'b1, 16'h1234, 16'h0630); // commit time
      queue_ticks(3);                                             // dots and second pulse
      queue_sample(PRESS_NONE, 1'b0, 1'b0, 16'h1234, 16'h0630);  // invalid time shows 0000
      queue_sample(PRESS_ACCEPT, 1'b1, 1'b1, 16'h1234, 16'h0630); // snooze
      queue_sample(PRESS_CANCEL, 1'b1, 1'b1, 16'h1234, 16'h0630); // silence only
      queue_sample(PRESS_ACCEPT | PRESS_CANCEL, 1'b0, 1'b1, 16'h1234, 16'h0630);
      queue_sample(PRESS_ACCEPT, 1'b0, 1'b1, 16'h1234, 16'h0630);
      queue_sample(PRESS_F1 | PRESS_F2, 1'b0, 1'b1, 16'h1234, 16'h0645); // alarm edit wins
      queue_sample(PRESS_UP | PRESS_ACCEPT, 1'b0, 1'b1, 16'h1234, 16'h0645);
      queue_sample(PRESS_ACCEPT | PRESS_CANCEL, 1'b0, 1'b1, 16'h1234, 16'h0645);
      queue_sample(PRESS_F1, 1'b0, 1'b1, 16'hFFFF, 16'h0000);    // non-BCD edit digits
      queue_sample(PRESS_UP, 1'b0, 1'b1, 16'hFFFF, 16'h0000);
      queue_sample(PRESS_DOWN, 1'b0, 1'b1, 16'hFFFF, 16'h0000);
      queue_sample(PRESS_ACCEPT, 1'b0, 1'b1, 16'hFFFF, 16'h0000);
      queue_sample(PRESS_UP, 1'b0, 1'b1, 16'hFFFF, 16'h0000);
      queue_sample(PRESS_DOWN, 1'b0, 1'b1, 16'hFFFF, 16'h0000);
      queue_sample(PRESS_CANCEL, 1'b0, 1'b0, 16'hFFFF, 16'h0000);
      drain();

      // Short lockout, small periods, heavy idling; the long receiver hold lands here.
      program_regs(12'd3, 12'($urandom_range(1, 20)), 12'($urandom_range(1, 20)));
      set_idling(50, 50);
      fill_random(220);
      drain();

      // No lockout and zero periods with no idling at all.
      program_regs(12'd0, 12'd0, 12'd0);
      set_idling(0, 0);
      fill_random(180);
      drain();

      // Largest values: keys mostly dropped, counters climb without wrapping.
      program_regs(12'd1023, 12'd4095, 12'd4095);
      set_idling(20, 20);
      fill_random(60);
      drain();

      // Lower the periods below the counts just reached: wrap on the next tick.
      program_regs(12'd2, 12'd1, 12'd1);
      set_idling(30, 70);
      fill_random(140);
      drain();

      // Lockout written with upper data bits set, random periods, a write to the hole.
      write_reg(CSR_UNMAPPED, 12'($urandom));
      program_regs(12'hC00 | 12'($urandom_range(0, 6)), 12'($urandom_range(1, 40)),
                   12'($urandom_range(0, 4095)));
      set_idling(70, 30);
      fill_random(150);
      drain();

      // let any stray word surface before the final verdict
      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_outputs.size() != 0) begin
         $error("%0d predicted result words never arrived", expected_outputs.size());
         mismatches++;
      end

      $display("Run: %0d ticks, %0d key samples, %0d register writes, %0d results taken",
               tick_total, sample_total, reg_writes, results_seen);
      $display("Predicted %0d display writes, %0d time commits, %0d alarm commits",
               display_writes, time_commits, alarm_commits);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
